@@ rtl/tlfq_pkg.sv @@
// tlfq_pkg: shared types and constants of the two-level feedback queue scheduler
// used by tlfq_cell and two_level_feedback_queue_scheduler; no dependencies
`timescale 1ns / 1ps
package tlfq_pkg;

  localparam int MaxJobsDefault = 16;
  localparam int IdW = 16;
  localparam int TimeW = 16;
  localparam int NowW = 24;
  localparam int QuantW = 8;
  localparam logic [QuantW-1:0] QuantumReset = 8'd2;

  // controls broadcast to every cell
  typedef struct packed {
    logic              clear;
    logic              tick;
    logic [NowW-1:0]   now;
    logic [QuantW-1:0] quantum;
  } ctl_t;

  // result record of one finished job
  typedef struct packed {
    logic [NowW-1:0] resp;
    logic [NowW-1:0] wait_t;
    logic [NowW-1:0] tat;
    logic [NowW-1:0] completion;
    logic [IdW-1:0]  id;
  } rec_t;

endpackage

@@ rtl/tlfq_cell.sv @@
// tlfq_cell: one job slot of the scheduler chain with its share of the priority pick
// depends on tlfq_pkg
`timescale 1ns / 1ps
module tlfq_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  tlfq_pkg::ctl_t           ctl,
  input  logic                     sel_load,
  input  logic [tlfq_pkg::IdW-1:0]   load_id,
  input  logic [tlfq_pkg::TimeW-1:0] load_arr,
  input  logic [tlfq_pkg::TimeW-1:0] load_burst,
  input  logic                     any0_in,
  input  logic                     any1_in,
  input  logic                     any0_all,
  output logic                     any0_out,
  output logic                     any1_out,
  output logic                     fin,
  output tlfq_pkg::rec_t           rec
);

  logic                       valid, done, started, lvl;
  logic [tlfq_pkg::IdW-1:0]   id;
  logic [tlfq_pkg::TimeW-1:0] arr, burst, remaining;
  logic [tlfq_pkg::NowW-1:0]  first_run;

  logic                       arrived, ready0, ready1, grant;
  logic [tlfq_pkg::TimeW-1:0] rem_next, used;
  logic [tlfq_pkg::NowW-1:0]  fr_eff, now_inc, tat;

  assign arrived  = {8'd0, arr} <= ctl.now;
  assign ready0   = valid && !done && arrived && !lvl;
  assign ready1   = valid && !done && arrived && lvl;
  assign any0_out = any0_in | ready0;
  assign any1_out = any1_in | ready1;
  assign grant    = ctl.tick && ((ready0 && !any0_in) || (ready1 && !any1_in && !any0_all));

  assign rem_next = remaining - 16'd1;
  assign used     = burst - rem_next;
  assign fr_eff   = started ? first_run : ctl.now;
  assign now_inc  = ctl.now + 24'd1;
  assign tat      = now_inc - {8'd0, arr};
  assign fin      = grant && (rem_next == '0);

  assign rec.id         = id;
  assign rec.completion = now_inc;
  assign rec.tat        = tat;
  assign rec.wait_t     = tat - {8'd0, burst};
  assign rec.resp       = fr_eff - {8'd0, arr};

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid   <= 1'b0;
      done    <= 1'b0;
      started <= 1'b0;
      lvl     <= 1'b0;
    end else if (sel_load) begin
      valid   <= 1'b1;
      done    <= 1'b0;
      started <= 1'b0;
      lvl     <= 1'b0;
    end else if (grant) begin
      started <= 1'b1;
      if (rem_next == '0) begin
        done <= 1'b1;
      end else if (!lvl && (used >= {8'd0, ctl.quantum})) begin
        lvl <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_load) begin
      id        <= load_id;
      arr       <= load_arr;
      burst     <= load_burst;
      remaining <= load_burst;
    end else if (grant) begin
      remaining <= rem_next;
      if (!started) begin
        first_run <= ctl.now;
      end
    end
  end

endmodule

@@ rtl/two_level_feedback_queue_scheduler.sv @@
// two_level_feedback_queue_scheduler: top level, job table as a chain of cells
// depends on tlfq_pkg and tlfq_cell
`timescale 1ns / 1ps
//
// channel   dir  handshake            payload
// s_axis    in   s_tvalid/s_tready    tdata: job_id, arrival_time, burst_length; tlast: last_job
// m_axis    out  m_tvalid/m_tready    tdata: job_id_res, completion, turnaround, waiting, response;
//                                     tlast: last_result
// cfg       in   cfg_valid/cfg_ready  cfg_data: quantum
//
// one job is taken per cycle while loading; a run then advances one simulated tick per
// cycle while the output register is free, idle ticks included, then clears the table
// the tick rate is set by the ripple priority pick through the cell chain
// a full output register holds the simulated clock until the record is taken
// rst is synchronous: table empty, time zero, quantum two
module two_level_feedback_queue_scheduler #(
  parameter int MAX_JOBS = tlfq_pkg::MaxJobsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // job_id, arrival_time, burst_length
  input  logic         s_tlast,   // last_job
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // job_id_res, completion, turnaround, waiting, response
  output logic         m_tlast,   // last_result
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data   // quantum
);

  localparam int CntW = $clog2(MAX_JOBS + 1);
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                       state;
  logic [CntW-1:0]            loaded, finished;
  logic [tlfq_pkg::NowW-1:0]  now;
  logic [tlfq_pkg::QuantW-1:0] quantum;

  logic                       s_acc, store, all_done, out_free, tick;
  tlfq_pkg::ctl_t             ctl;
  logic [MAX_JOBS:0]          any0, any1;
  logic [MAX_JOBS-1:0]        fin, sel_load;
  tlfq_pkg::rec_t             recs [MAX_JOBS];
  tlfq_pkg::rec_t             rec_sel;
  logic                       any_fin;

  assign s_tready  = (state == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  // zero bursts and items beyond the table are dropped
  assign store     = s_acc && (s_tdata[47:32] != '0) && (loaded < CntW'(MAX_JOBS));
  assign all_done  = (finished == loaded);
  assign out_free  = !m_tvalid || m_tready;
  assign tick      = (state == ST_RUN) && !all_done && out_free;

  assign ctl.clear   = (state == ST_RUN) && all_done;
  assign ctl.tick    = tick;
  assign ctl.now     = now;
  assign ctl.quantum = (quantum == '0) ? 8'd1 : quantum;

  assign any0[0] = 1'b0;
  assign any1[0] = 1'b0;

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    assign sel_load[i] = store && (loaded == CntW'(i));
    tlfq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sel_load   (sel_load[i]),
      .load_id    (s_tdata[15:0]),
      .load_arr   (s_tdata[31:16]),
      .load_burst (s_tdata[47:32]),
      .any0_in    (any0[i]),
      .any1_in    (any1[i]),
      .any0_all   (any0[MAX_JOBS]),
      .any0_out   (any0[i+1]),
      .any1_out   (any1[i+1]),
      .fin        (fin[i]),
      .rec        (recs[i])
    );
  end

  // at most one cell finishes per tick
  always_comb begin
    rec_sel = '0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      if (fin[i]) begin
        rec_sel = rec_sel | recs[i];
      end
    end
  end
  assign any_fin = |fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      loaded   <= '0;
      finished <= '0;
      now      <= '0;
      quantum  <= tlfq_pkg::QuantumReset;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        quantum <= cfg_data;
      end
      // a new record takes precedence over the one leaving
      if (tick && any_fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (store) begin
            loaded <= loaded + CntW'(1);
          end
          if (s_acc && s_tlast) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (all_done) begin
            // batch over: empty the table for the next one
            state    <= ST_LOAD;
            loaded   <= '0;
            finished <= '0;
            now      <= '0;
          end else if (tick) begin
            now <= now + 24'd1;
            if (any_fin) begin
              finished <= finished + CntW'(1);
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // record register, loaded only when a job finishes
  always_ff @(posedge clk) begin
    if (tick && any_fin) begin
      m_tdata <= {rec_sel.resp, rec_sel.wait_t, rec_sel.tat, rec_sel.completion, rec_sel.id};
      m_tlast <= ((finished + CntW'(1)) == loaded);
    end
  end

endmodule
